### rtl/core/running_sample_statistics_top_assert.svh
// assertion macros for the running sample statistics block
// no dependencies; included by the top level
`ifndef RUNNING_SAMPLE_STATISTICS_TOP_ASSERT_SVH
`define RUNNING_SAMPLE_STATISTICS_TOP_ASSERT_SVH
`ifndef SYNTHESIS
`define RSS_ASSERT_IMPL(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error("%m failed");
`define RSS_ASSERT_NORST(label, clk, prop) \
   label: assert property (@(posedge clk) prop) else $error("%m failed");
`else
`define RSS_ASSERT_IMPL(label, clk, rst, prop)
`define RSS_ASSERT_NORST(label, clk, prop)
`endif
`endif

### rtl/core/rss_pkg.sv
// shared constants and types for the running sample statistics block
// no dependencies
`timescale 1ns / 1ps
package rss_pkg;
   localparam int MaxCount   = 4096;
   localparam int SampleBits = 16;
   localparam int CntW       = $clog2(MaxCount + 1);
   localparam int SumW       = SampleBits + CntW;
   localparam int SqW        = 2 * SampleBits + CntW;
   localparam int SprW       = SqW + CntW + 1;
   localparam int NumW       = SprW + 16;
   localparam int DenW       = 2 * CntW;
   localparam int RootInW    = 48;
   localparam int RootW      = 24;
   localparam int SqCntW     = $clog2(NumW + 1);
   localparam int RtCntW     = $clog2(RootW + 1);
   localparam int ResultW    = 16 + 16 + 24 + 24 + 24 + 1 + CntW + 1;

   // job handed from the front to the back
   typedef struct packed {
      logic [CntW-1:0]  count;
      logic [SumW-1:0]  sum;
      logic [SqW-1:0]   sum_sq;
      logic [15:0]      min_value;
      logic [15:0]      max_value;
      logic             full;
   } job_type;

   localparam int JobW = $bits(job_type);
endpackage

### rtl/core/rss_stream_if.sv
// valid/ready channel with a generic payload width
// no dependencies
`timescale 1ns / 1ps
interface rss_stream_if #(parameter int W = 16);
   logic         valid;
   logic         ready;
   logic [W-1:0] data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

### rtl/core/rss_front.sv
// front end: accumulates count, sums, minimum and maximum per sample
// depends on rss_pkg
`timescale 1ns / 1ps
module rss_front import rss_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            in_valid,
   output logic            in_ready,
   input  logic [15:0]     in_sample,
   output logic            job_valid,
   input  logic            job_ready,
   output job_type         job_data
);
   logic [CntW-1:0] count_ff, count_in;
   logic [SumW-1:0] sum_ff, sum_in;
   logic [SqW-1:0]  sq_ff, sq_in;
   logic [15:0]     min_ff, min_in, max_ff, max_in;
   logic [SampleBits-1:0] s;
   logic [2*SampleBits-1:0] sq_s;
   logic            full;
   logic            fire;

   assign in_ready  = job_ready;
   assign job_valid = in_valid;
   assign fire      = in_valid && job_ready;
   assign s         = in_sample[SampleBits-1:0];
   assign sq_s      = s * s;
   assign full      = (count_ff >= CntW'(MaxCount));

   always_comb begin
      count_in = count_ff;
      sum_in   = sum_ff;
      sq_in    = sq_ff;
      min_in   = min_ff;
      max_in   = max_ff;
      if (!full) begin
         count_in = count_ff + 1'b1;
         sum_in   = sum_ff + SumW'(s);
         sq_in    = sq_ff + SqW'(sq_s);
         if (16'(s) < min_ff) min_in = 16'(s);
         if (16'(s) > max_ff) max_in = 16'(s);
      end
   end

   assign job_data = '{count: count_in, sum: sum_in, sum_sq: sq_in,
                       min_value: min_in, max_value: max_in, full: full};

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         sum_ff   <= '0;
         sq_ff    <= '0;
         min_ff   <= 16'(SampleBits == 16 ? 16'hFFFF : (1 << SampleBits) - 1);
         max_ff   <= '0;
      end else if (fire) begin
         count_ff <= count_in;
         sum_ff   <= sum_in;
         sq_ff    <= sq_in;
         min_ff   <= min_in;
         max_ff   <= max_in;
      end
   end
endmodule

### rtl/core/rss_queue.sv
// two-entry queue between front and back
// depends on rss_pkg
`timescale 1ns / 1ps
module rss_queue import rss_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    in_valid,
   output logic    in_ready,
   input  job_type in_data,
   output logic    out_valid,
   input  logic    out_ready,
   output job_type out_data
);
   job_type    mem_ff [2];
   logic       wp_ff, rp_ff;
   logic [1:0] cnt_ff;
   logic       push, pop;

   assign in_ready  = (cnt_ff != 2'd2);
   assign out_valid = (cnt_ff != 2'd0);
   assign out_data  = mem_ff[rp_ff];
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;

   always_ff @(posedge clock) begin
      if (push) mem_ff[wp_ff] <= in_data;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= 1'b0;
         rp_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         if (push) wp_ff <= ~wp_ff;
         if (pop)  rp_ff <= ~rp_ff;
         cnt_ff <= cnt_ff + {1'b0, push} - {1'b0, pop};
      end
   end
endmodule

### rtl/core/rss_back.sv
// back end: spread, serial divisions and square roots, result register
// depends on rss_pkg
`timescale 1ns / 1ps
module rss_back import rss_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               job_valid,
   output logic               job_ready,
   input  job_type            job_data,
   output logic               rsp_valid_o,
   input  logic               rsp_ready_i,
   output logic [ResultW-1:0] rsp_data_o
);
   typedef enum logic [7:0] {
      S_IDLE = 8'b00000001, S_MUL  = 8'b00000010, S_MUL2 = 8'b00000100,
      S_DIV  = 8'b00001000, S_ROOT = 8'b00010000, S_NEXT = 8'b00100000,
      S_DONE = 8'b01000000, S_OUT  = 8'b10000000
   } state_type;

   state_type       state_ff, state_in;
   job_type         job_ff;
   logic [SprW-1:0] a_ff, b_ff;
   logic [SprW-1:0] spread_ff;
   logic [1:0]      phase_ff;
   logic [NumW-1:0] num_ff;
   logic [DenW-1:0] den_ff;
   logic [DenW:0]   rem_ff;
   logic [SqCntW-1:0] dcnt_ff;
   logic [RootInW-1:0] rx_ff;
   logic [RootInW-1:0] rres_ff;
   logic [RtCntW-1:0]  rcnt_ff;
   logic            ovf_ff;
   logic [23:0]     mean_ff, pdev_ff, sdev_ff;
   logic            out_valid_ff;
   logic [ResultW-1:0] out_ff;

   logic [DenW:0]   rem_sh;
   logic [RootInW-1:0] rbit, rtry;
   logic           more;

   assign job_ready   = (state_ff == S_IDLE);
   assign rsp_valid_o = out_valid_ff;
   assign rsp_data_o  = out_ff;
   assign rem_sh      = {rem_ff[DenW-1:0], num_ff[NumW-1]};
   assign rbit        = RootInW'(1) << {rcnt_ff, 1'b0};
   assign rtry        = rres_ff + rbit;
   assign more        = (job_ff.count > CntW'(1));

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: if (job_valid) state_in = S_MUL;
         S_MUL:  state_in = S_MUL2;
         S_MUL2: state_in = S_DIV;
         S_DIV:  if (dcnt_ff == '0) state_in = S_ROOT;
         S_ROOT: if (rcnt_ff == '0) state_in = S_NEXT;
         S_NEXT: state_in = (phase_ff == 2'd1 || (phase_ff == 2'd2 && more)) ? S_DIV : S_DONE;
         S_DONE: if (!out_valid_ff) state_in = S_OUT;
         S_OUT:  state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      case (state_ff)
         S_IDLE: begin
            job_ff   <= job_data;
            a_ff     <= SprW'(job_data.count) * SprW'(job_data.sum_sq);
            b_ff     <= SprW'(job_data.sum) * SprW'(job_data.sum);
            phase_ff <= 2'd0;
         end
         S_MUL: begin
            spread_ff <= a_ff - b_ff;
            // mean via the same divider
            num_ff  <= NumW'({job_ff.sum, 8'd0});
            den_ff  <= DenW'(job_ff.count);
            rem_ff  <= '0;
            dcnt_ff <= SqCntW'(NumW);
            phase_ff <= 2'd1;
         end
         S_MUL2: ;
         S_DIV: begin
            if (dcnt_ff != '0) begin
               if (rem_sh >= {1'b0, den_ff}) begin
                  rem_ff <= rem_sh - {1'b0, den_ff};
                  num_ff <= {num_ff[NumW-2:0], 1'b1};
               end else begin
                  rem_ff <= rem_sh;
                  num_ff <= {num_ff[NumW-2:0], 1'b0};
               end
               dcnt_ff <= dcnt_ff - 1'b1;
            end else begin
               ovf_ff  <= (num_ff >> RootInW) != '0;
               rx_ff   <= num_ff[RootInW-1:0];
               rres_ff <= '0;
               rcnt_ff <= RtCntW'(RootW - 1);
               if (phase_ff == 2'd1) begin
                  mean_ff <= ((num_ff >> 24) != '0) ? 24'hFFFFFF : num_ff[23:0];
               end
            end
         end
         S_ROOT: begin
            if (phase_ff == 2'd1) begin
               rcnt_ff <= '0;
            end else begin
               if (rx_ff >= rtry) begin
                  rx_ff   <= rx_ff - rtry;
                  rres_ff <= (rres_ff >> 1) + rbit;
               end else begin
                  rres_ff <= rres_ff >> 1;
               end
               if (rcnt_ff != '0) rcnt_ff <= rcnt_ff - 1'b1;
            end
         end
         S_NEXT: begin
            if (phase_ff == 2'd2) begin
               pdev_ff <= ovf_ff ? 24'hFFFFFF : rres_ff[23:0];
            end else if (phase_ff == 2'd3) begin
               sdev_ff <= ovf_ff ? 24'hFFFFFF : rres_ff[23:0];
            end else if (phase_ff == 2'd1) begin
               sdev_ff <= '0;
            end
            num_ff  <= NumW'({spread_ff, 16'd0});
            rem_ff  <= '0;
            dcnt_ff <= SqCntW'(NumW);
            if (phase_ff == 2'd1)
               den_ff <= DenW'(job_ff.count) * DenW'(job_ff.count);
            else
               den_ff <= DenW'(job_ff.count) * DenW'(job_ff.count - 1'b1);
            phase_ff <= phase_ff + 2'd1;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (state_ff == S_OUT) out_valid_ff <= 1'b1;
         else if (rsp_valid_o && rsp_ready_i) out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == S_OUT)
         out_ff <= {job_ff.min_value, job_ff.max_value, mean_ff, pdev_ff,
                    more ? sdev_ff : 24'd0, more, 13'(job_ff.count),
                    job_ff.full};
   end
endmodule

### rtl/core/running_sample_statistics_top.sv
// running sample statistics: min, max, mean and deviations of a sample stream
// depends on rss_pkg, rss_stream_if, rss_front, rss_queue, rss_back and the assert header
// One result per sample transfer. The front end updates count, sums, minimum and
// maximum in the accepting cycle; a two-entry queue feeds the back end, which
// forms the spread and runs one shared 75-step bit-serial divider three times
// (twice for the first sample, which has no sample deviation to compute), every
// pass after the first followed by a 24-step square root. A result still waiting
// at the output holds the back end in its done state. Statistics saturate at
// 0xFFFFFF; past 4096 samples input is reported with full_res set and ignored.
`timescale 1ns / 1ps
`include "running_sample_statistics_top_assert.svh"
module running_sample_statistics_top import rss_pkg::*; (
   input  logic clock,
   input  logic reset,
   rss_stream_if.sink   req,
   rss_stream_if.source rsp
);
   logic    jv, jr, qv, qr;
   job_type jd, qd;
   logic [ResultW-1:0] od;

   rss_front u_front (.clock, .reset, .in_valid(req.valid), .in_ready(req.ready),
      .in_sample(req.data[15:0]), .job_valid(jv), .job_ready(jr), .job_data(jd));
   rss_queue u_queue (.clock, .reset, .in_valid(jv), .in_ready(jr), .in_data(jd),
      .out_valid(qv), .out_ready(qr), .out_data(qd));
   rss_back u_back (.clock, .reset, .job_valid(qv), .job_ready(qr), .job_data(qd),
      .rsp_valid_o(rsp.valid), .rsp_ready_i(rsp.ready), .rsp_data_o(od));

   assign rsp.data = od;

   `RSS_ASSERT_IMPL(a_count_nonzero, clock, reset, rsp.valid |-> od[13:1] != 13'd0)
   `RSS_ASSERT_IMPL(a_min_le_max, clock, reset, rsp.valid |-> od[118:103] <= od[102:87])
   `RSS_ASSERT_NORST(a_reset_idle, clock, reset |=> !rsp.valid)
endmodule

### dv/running_sample_statistics_top_test.sv
// self-checking testbench for running_sample_statistics_top: streams samples, predicts
// min, max, mean and deviations per transfer, and compares each result field by field
// depends on rss_pkg, rss_stream_if and running_sample_statistics_top
`timescale 1ns / 1ps
module running_sample_statistics_top_test;
   import rss_pkg::*;

   localparam int RspW = 16 + 16 + 24 + 24 + 24 + 1 + 13 + 1;
   localparam logic [23:0] Sat24 = 24'hFFFFFF;

   typedef struct packed {
      logic [15:0] min_value;
      logic [15:0] max_value;
      logic [23:0] mean_q8;
      logic [23:0] pop_dev_q8;
      logic [23:0] smp_dev_q8;
      logic        smp_dev_valid;
      logic [12:0] sample_count;
      logic        full_res;
   } stats_type;

   logic clock;
   logic reset;

   rss_stream_if #(.W(16))   req ();
   rss_stream_if #(.W(RspW)) rsp ();

   running_sample_statistics_top i_dut (
      .clock(clock),
      .reset(reset),
      .req  (req.sink),
      .rsp  (rsp.source)
   );

   logic [15:0] pending_samples[$];
   stats_type   expected_stats[$];
   int          error_count;
   int          sent_count;
   int          checked_count;

   // predictor state
   logic [63:0] acc_count;
   logic [63:0] acc_sum;
   logic [63:0] acc_sum_sq;
   logic [15:0] acc_min;
   logic [15:0] acc_max;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic logic [23:0] floor_root(logic [47:0] x);
      logic [23:0] r;
      logic [23:0] t;
      r = '0;
      for (int b = 23; b >= 0; b--) begin
         t = r | (24'd1 << b);
         if ({24'd0, t} * {24'd0, t} <= x) r = t;
      end
      return r;
   endfunction

   function automatic logic [23:0] deviation_q8(logic [127:0] spread, logic [63:0] d);
      logic [127:0] q;
      q = (spread << 16) / d;
      if (q >= (128'd1 << 48)) return Sat24;
      return floor_root(q[47:0]);
   endfunction

   function automatic stats_type accumulate_sample(logic [15:0] s);
      stats_type    r;
      logic [63:0]  m;
      logic [127:0] spread;
      r = '0;
      if (acc_count >= MaxCount) begin
         r.full_res = 1'b1;
      end else begin
         acc_count  = acc_count + 1;
         acc_sum    = acc_sum + s;
         acc_sum_sq = acc_sum_sq + 64'(s) * 64'(s);
         if (s < acc_min) acc_min = s;
         if (s > acc_max) acc_max = s;
      end
      m = (acc_sum << 8) / acc_count;
      r.mean_q8 = (m > 64'(Sat24)) ? Sat24 : m[23:0];
      spread = 128'(acc_count) * 128'(acc_sum_sq) - 128'(acc_sum) * 128'(acc_sum);
      r.pop_dev_q8 = deviation_q8(spread, acc_count * acc_count);
      if (acc_count > 1) begin
         r.smp_dev_valid = 1'b1;
         r.smp_dev_q8 = deviation_q8(spread, acc_count * (acc_count - 1));
      end
      r.min_value    = acc_min;
      r.max_value    = acc_max;
      r.sample_count = acc_count[12:0];
      return r;
   endfunction

   task automatic queue_sample(logic [15:0] s);
      pending_samples.insert(pending_samples.size(), s);
   endtask

   task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
      $display("mismatch at result %0d: %s got %0h expected %0h",
               checked_count, what, got, want);
      error_count++;
   endtask

   // driver: bursts of random length with random gaps
   int burst_left;
   int gap_left;
   always @(posedge clock) begin
      if (reset) begin
         req.valid  <= 1'b0;
         req.data   <= '0;
         burst_left <= 0;
         gap_left   <= 0;
         acc_count  <= '0;
         acc_sum    <= '0;
         acc_sum_sq <= '0;
         acc_min    <= '1;
         acc_max    <= '0;
      end else begin
         logic        took;
         logic [15:0] nxt;
         took = req.valid && req.ready;
         if (took) begin
            expected_stats.insert(expected_stats.size(), accumulate_sample(req.data));
            void'(pending_samples.pop_front());
            sent_count++;
         end
         if (req.valid && !took) begin
            // hold until transfer
         end else if (gap_left > 0) begin
            req.valid <= 1'b0;
            gap_left  <= gap_left - 1;
         end else if (pending_samples.size() > 0) begin
            nxt = pending_samples[0];
            req.valid <= 1'b1;
            req.data  <= nxt;
            if (burst_left <= 1) begin
               burst_left <= $urandom_range(1, 8);
               gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
            end else begin
               burst_left <= burst_left - 1;
            end
         end else begin
            req.valid <= 1'b0;
         end
      end
   end

   // monitor with its own stall pattern
   int stall_mode;
   always @(posedge clock) begin
      if (reset) begin
         rsp.ready  <= 1'b0;
         stall_mode <= 0;
      end else begin
         if (rsp.valid && rsp.ready) begin
            stats_type got;
            stats_type want;
            got = stats_type'(rsp.data);
            if (expected_stats.size() == 0) begin
               report_mismatch("unexpected result count", 64'(got.sample_count), 64'd0);
            end else begin
               want = expected_stats.pop_front();
               if (got.min_value != want.min_value)
                  report_mismatch("min_value", got.min_value, want.min_value);
               if (got.max_value != want.max_value)
                  report_mismatch("max_value", got.max_value, want.max_value);
               if (got.mean_q8 != want.mean_q8)
                  report_mismatch("mean_q8", got.mean_q8, want.mean_q8);
               if (got.pop_dev_q8 != want.pop_dev_q8)
                  report_mismatch("pop_dev_q8", got.pop_dev_q8, want.pop_dev_q8);
               if (got.smp_dev_q8 != want.smp_dev_q8)
                  report_mismatch("smp_dev_q8", got.smp_dev_q8, want.smp_dev_q8);
               if (got.smp_dev_valid != want.smp_dev_valid)
                  report_mismatch("smp_dev_valid", got.smp_dev_valid, want.smp_dev_valid);
               if (got.sample_count != want.sample_count)
                  report_mismatch("sample_count", got.sample_count, want.sample_count);
               if (got.full_res != want.full_res)
                  report_mismatch("full_res", got.full_res, want.full_res);
               checked_count++;
            end
         end
         if ($urandom_range(0, 199) == 0) stall_mode <= $urandom_range(0, 2);
         case (stall_mode)
            0: rsp.ready <= 1'b1;
            1: rsp.ready <= ($urandom_range(0, 3) != 0);
            default: rsp.ready <= ($urandom_range(0, 4) == 0);
         endcase
      end
   end

   initial begin
      int total;
      error_count = 0;
      sent_count = 0;
      checked_count = 0;
      req.valid = 1'b0;
      req.data  = '0;
      rsp.ready = 1'b0;
      reset = 1'b1;
      // directed: single sample, extremes, repeated values
      queue_sample(16'd0);
      queue_sample(16'hFFFF);
      queue_sample(16'hFFFF);
      queue_sample(16'd0);
      queue_sample(16'd1);
      queue_sample(16'h8000);
      queue_sample(16'h7FFF);
      queue_sample(16'h5555);
      queue_sample(16'hAAAA);
      queue_sample(16'd1234);
      // random mix of small, large, mid-scale and arbitrary values
      total = 1000;
      while (pending_samples.size() < total) begin
         case ($urandom_range(0, 5))
            0: queue_sample(16'($urandom_range(0, 15)));
            1: queue_sample(16'(16'hFFFF - $urandom_range(0, 15)));
            2: queue_sample(16'(32768 + $urandom_range(0, 64) - 32));
            default: queue_sample(16'($urandom));
         endcase
      end
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      wait (pending_samples.size() == 0 && !req.valid);
      wait (expected_stats.size() == 0);
      repeat (800) @(posedge clock);
      $display("streamed %0d samples in random bursts and compared %0d results",
               sent_count, checked_count);
      $display("under a changing output stall pattern");
      if (error_count == 0 && expected_stats.size() == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

   initial begin
      #80ms;
      $display("timeout with %0d results outstanding", expected_stats.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
   end
endmodule
